[hdl/cartesian_to_polar_macros.svh]
`ifndef CARTESIAN_TO_POLAR_MACROS_SVH
`define CARTESIAN_TO_POLAR_MACROS_SVH

// Same-cycle implication, held off during reset.
`define C2P_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("c2p check failed");

// Next-cycle implication, held off during reset.
`define C2P_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("c2p check failed");

// Next-cycle implication that also runs through reset.
`define C2P_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("c2p check failed");

`endif

[hdl/c2p_pkg.sv]
`default_nettype none

package c2p_pkg;

    // Result field widths
    localparam int ANGLE_W    = 20;
    localparam int DIST_W     = 42;
    localparam int DIST_FRAC  = 8;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;

    // CORDIC datapath
    localparam int NORM_W     = 59;   // normalized vector lives in [2^58, 2^59)
    localparam int NORM_STEPS = 6;    // shift by 32, 16, 8, 4, 2, 1
    localparam int XY_W       = 62;
    localparam int Z_W        = 35;   // Q30 angle accumulator
    localparam int Z_DROP     = 14;   // Q30 -> Q16
    localparam logic signed [Z_W-1:0] Z_ROUND  = 35'sd8192;
    localparam logic signed [Z_W-1:0] PI_Q30   = 35'sd3373259426;

    // Angle constants, Q16
    localparam logic signed [ANGLE_W-1:0] ANGLE_PI           = 20'sd205887;
    localparam logic signed [ANGLE_W-1:0] ANGLE_NEG_PI       = -20'sd205887;
    localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI      = 20'sd102944;
    localparam logic signed [ANGLE_W-1:0] ANGLE_NEG_HALF_PI  = -20'sd102944;
    localparam logic signed [ANGLE_W-1:0] ANGLE_AT_ORIGIN    = -20'sd327680;

    // Starting value of the angle accumulator
    typedef enum logic [1:0] {
        ZS_ZERO   = 2'd0,
        ZS_POS_PI = 2'd1,
        ZS_NEG_PI = 2'd2
    } t_zsel;

    // Vector control handed to the CORDIC with the magnitudes
    typedef struct packed {
        logic  yneg;
        t_zsel zsel;
    } t_vec_ctl;

    // Per-item flags that bypass the arithmetic
    typedef struct packed {
        logic                      at_origin;
        logic                      axis;
        logic signed [ANGLE_W-1:0] axis_angle;
    } t_flags;

    // atan(2^-k) in Q30
    function automatic logic [29:0] atan_q30(input logic [4:0] k);
        logic [29:0] v;
        case (k)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd31:   v = 30'd0;
            default: v = 30'd1 << (5'd30 - k);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/c2p_delay.sv]
`default_nettype none

module c2p_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    if (DEPTH == 0) begin : g_none
        assign o_data = i_data;
    end else begin : g_line
        logic [WIDTH-1:0] r_tap [DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tap[0] <= i_data;
                for (int k = 1; k < DEPTH; k++) begin
                    r_tap[k] <= r_tap[k-1];
                end
            end
        end

        assign o_data = r_tap[DEPTH-1];
    end

endmodule

`default_nettype wire

[hdl/c2p_isqrt.sv]
`default_nettype none

// Digit-by-digit integer square root, one root bit per stage.
module c2p_isqrt #(
    parameter int RAD_W = 82
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [RAD_W-1:0]     i_rad,
    output logic [RAD_W/2-1:0]   o_root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 1;

    logic [RAD_W-1:0]  r_rad  [ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_step
        logic [RAD_W-1:0]  w_rad;
        logic [REM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [REM_W+1:0]  w_acc;
        logic [REM_W+1:0]  w_trial;
        logic [REM_W+1:0]  w_diff;
        logic              w_ge;

        if (j == 0) begin : g_first
            assign w_rad  = i_rad;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_rad  = r_rad[j-1];
            assign w_rem  = r_rem[j-1];
            assign w_root = r_root[j-1];
        end

        // bring down the next pair, try (4*root + 1)
        assign w_acc   = {w_rem, w_rad[RAD_W-1 -: 2]};
        assign w_trial = {1'b0, w_root, 2'b01};
        assign w_diff  = w_acc - w_trial;
        assign w_ge    = (w_acc >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[j] <= {w_root[ROOT_W-2:0], w_ge};
            end
        end

        if (j < ROOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[j] <= w_rad << 2;
                    r_rem[j] <= w_ge ? w_diff[REM_W-1:0] : w_acc[REM_W-1:0];
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

`default_nettype wire

[hdl/c2p_cordic.sv]
`default_nettype none

// Vectoring CORDIC: normalize, ITERATIONS rotation stages, round to Q16.
module c2p_cordic
    import c2p_pkg::*;
#(
    parameter int MAG_W      = 33,
    parameter int ITERATIONS = 18
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [MAG_W-1:0]          i_ux,
    input  logic [MAG_W-1:0]          i_uy,
    input  t_vec_ctl                  i_ctl,
    output logic signed [ANGLE_W-1:0] o_angle
);

    // ---------------- normalization: shift both until bit 58 is set
    logic [NORM_W-1:0] r_nx   [NORM_STEPS];
    logic [NORM_W-1:0] r_ny   [NORM_STEPS];
    t_vec_ctl          r_nctl [NORM_STEPS];

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - k);
        logic [NORM_W-1:0] w_x;
        logic [NORM_W-1:0] w_y;
        logic [NORM_W-1:0] w_or;
        t_vec_ctl          w_ctl;
        logic              w_top_zero;

        if (k == 0) begin : g_first
            assign w_x   = NORM_W'(i_ux);
            assign w_y   = NORM_W'(i_uy);
            assign w_ctl = i_ctl;
        end else begin : g_next
            assign w_x   = r_nx[k-1];
            assign w_y   = r_ny[k-1];
            assign w_ctl = r_nctl[k-1];
        end

        assign w_or       = w_x | w_y;
        assign w_top_zero = (w_or[NORM_W-1 -: SH] == '0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[k]   <= w_top_zero ? (w_x << SH) : w_x;
                r_ny[k]   <= w_top_zero ? (w_y << SH) : w_y;
                r_nctl[k] <= w_ctl;
            end
        end
    end

    // ---------------- rotation stages
    logic signed [XY_W-1:0] r_x [ITERATIONS-1];
    logic signed [XY_W-1:0] r_y [ITERATIONS-1];
    logic signed [Z_W-1:0]  r_z [ITERATIONS];

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
        logic signed [XY_W-1:0] w_x;
        logic signed [XY_W-1:0] w_y;
        logic signed [Z_W-1:0]  w_z;
        logic signed [Z_W-1:0]  w_step;
        logic                   w_up;

        if (i == 0) begin : g_first
            logic signed [XY_W-1:0] w_y_mag;
            assign w_x     = XY_W'(r_nx[NORM_STEPS-1]);
            assign w_y_mag = XY_W'(r_ny[NORM_STEPS-1]);
            assign w_y     = r_nctl[NORM_STEPS-1].yneg ? -w_y_mag : w_y_mag;
            always_comb begin
                case (r_nctl[NORM_STEPS-1].zsel)
                    ZS_POS_PI: w_z = PI_Q30;
                    ZS_NEG_PI: w_z = -PI_Q30;
                    default:   w_z = '0;
                endcase
            end
        end else begin : g_next
            assign w_x = r_x[i-1];
            assign w_y = r_y[i-1];
            assign w_z = r_z[i-1];
        end

        // rotate clockwise while y is above the axis
        assign w_up   = !w_y[XY_W-1] && (w_y != '0);
        assign w_step = Z_W'(atan_q30(5'(i)));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z[i] <= w_up ? (w_z + w_step) : (w_z - w_step);
            end
        end

        if (i < ITERATIONS - 1) begin : g_carry
            logic signed [XY_W-1:0] w_xs;
            logic signed [XY_W-1:0] w_ys;
            assign w_xs = w_x >>> i;
            assign w_ys = w_y >>> i;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[i] <= w_up ? (w_x + w_ys) : (w_x - w_ys);
                    r_y[i] <= w_up ? (w_y - w_xs) : (w_y + w_xs);
                end
            end
        end
    end

    // ---------------- round half up to Q16, clamp to +/- pi
    logic signed [Z_W-1:0]        w_zr_full;
    logic signed [Z_W-Z_DROP-1:0] w_zr;

    assign w_zr_full = r_z[ITERATIONS-1] + Z_ROUND;
    assign w_zr      = w_zr_full[Z_W-1:Z_DROP];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_zr > ANGLE_PI) begin
                o_angle <= ANGLE_PI;
            end else if (w_zr < ANGLE_NEG_PI) begin
                o_angle <= ANGLE_NEG_PI;
            end else begin
                o_angle <= w_zr[ANGLE_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

[hdl/cartesian_to_polar.sv]
`default_nettype none

// ---------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        sink       i_in_valid / o_in_ready    i_point_x, i_point_y
//  out       source     o_out_valid / i_out_ready  o_angle, o_distance, o_at_origin
//  cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  Takes one word per cycle while the out channel does not stall. Of the two
//  branches, the longer one sets when a result leaves; at the defaults that is
//  the square-root pipeline, one root bit per stage.
//  Reset is synchronous and active low; it clears the valid bits and the
//  origin, and no clearing pass follows. A stall on the out channel freezes
//  the whole pipeline; the input register still takes one word into a hole.
// ---------------------------------------------------------------------------
module cartesian_to_polar
    import c2p_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int ITERATIONS  = 18
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [COORD_WIDTH-1:0]    i_point_x,
    input  logic [COORD_WIDTH-1:0]    i_point_y,

    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [ANGLE_W-1:0] o_angle,
    output logic [DIST_W-1:0]         o_distance,
    output logic                      o_at_origin,

    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [COORD_WIDTH-1:0]    i_cfg_data
);

    // Offset magnitude needs one bit more than a coordinate.
    localparam int MAG_W   = COORD_WIDTH + 1;
    // Square split into halves so no multiplier exceeds ~25 bits.
    localparam int HALF_LO = (MAG_W + 1) / 2;
    localparam int HALF_HI = MAG_W - HALF_LO;
    localparam int PHH_W   = 2 * HALF_HI;
    localparam int PHL_W   = HALF_HI + HALF_LO;
    localparam int PLL_W   = 2 * HALF_LO;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int RAD_W   = SQ_W + 2 * DIST_FRAC;
    localparam int ROOT_W  = RAD_W / 2;

    // Stage at which each branch's result sits in a register.
    localparam int DIST_STAGE  = 5 + ROOT_W;
    localparam int ANGLE_STAGE = 2 + NORM_STEPS + ITERATIONS + 1;
    localparam int LAST        = (DIST_STAGE > ANGLE_STAGE) ? DIST_STAGE : ANGLE_STAGE;

    // ------------------------------------------------------------ config
    logic [COORD_WIDTH-1:0] r_origin_x;
    logic [COORD_WIDTH-1:0] r_origin_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ORIGIN_X: r_origin_x <= i_cfg_data;
                REG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ flow control
    // Advance everything past the input register when the output word is
    // gone or leaving; the input register also fills a hole while stalled.
    logic         w_adv;
    logic         w_load0;
    logic         r_v0;
    logic [LAST:1] r_vld;
    logic         r_vout;

    assign w_adv       = !r_vout || i_out_ready;
    assign w_load0     = w_adv || !r_v0;
    assign o_in_ready  = w_load0;
    assign o_out_valid = r_vout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_vld  <= '0;
            r_vout <= 1'b0;
        end else begin
            if (w_load0) begin
                r_v0 <= i_in_valid;
            end
            if (w_adv) begin
                r_vld  <= {r_vld[LAST-1:1], r_v0};
                r_vout <= r_vld[LAST];
            end
        end
    end

    // ------------------------------------------------------------ stage 0: capture
    logic [COORD_WIDTH-1:0] r_px;
    logic [COORD_WIDTH-1:0] r_py;

    always_ff @(posedge i_clk) begin
        if (w_load0) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
    end

    // ------------------------------------------------------------ stage 1: offset
    logic signed [MAG_W-1:0] r_dx;
    logic signed [MAG_W-1:0] r_dy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx <= {r_px[COORD_WIDTH-1], r_px} - {r_origin_x[COORD_WIDTH-1], r_origin_x};
            r_dy <= {r_py[COORD_WIDTH-1], r_py} - {r_origin_y[COORD_WIDTH-1], r_origin_y};
        end
    end

    // ------------------------------------------------------------ stage 2: classify
    logic     w_zx, w_zy, w_nx, w_ny;
    t_flags   w_flags;
    t_vec_ctl w_ctl;

    assign w_zx = (r_dx == '0);
    assign w_zy = (r_dy == '0);
    assign w_nx = r_dx[MAG_W-1];
    assign w_ny = r_dy[MAG_W-1];

    // Points on an axis take an exact angle; the CORDIC result is dropped.
    assign w_flags.at_origin  = w_zx && w_zy;
    assign w_flags.axis       = w_zx || w_zy;
    assign w_flags.axis_angle = w_zy ? (w_nx ? ANGLE_PI : '0)
                                     : (w_ny ? ANGLE_NEG_HALF_PI : ANGLE_HALF_PI);

    // Left half plane: turn the vector by pi and preload the accumulator.
    assign w_ctl.yneg = w_nx ? (!w_ny && !w_zy) : w_ny;
    assign w_ctl.zsel = !w_nx ? ZS_ZERO : ((w_ny || w_zy) ? ZS_NEG_PI : ZS_POS_PI);

    logic [MAG_W-1:0] r_mx;
    logic [MAG_W-1:0] r_my;
    t_vec_ctl         r_ctl;
    t_flags           r_flags;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mx    <= w_nx ? MAG_W'(-r_dx) : MAG_W'(r_dx);
            r_my    <= w_ny ? MAG_W'(-r_dy) : MAG_W'(r_dy);
            r_ctl   <= w_ctl;
            r_flags <= w_flags;
        end
    end

    // ------------------------------------------------------------ stages 3..5: squares
    logic [PHH_W-1:0] r_xhh, r_yhh;
    logic [PHL_W-1:0] r_xhl, r_yhl;
    logic [PLL_W-1:0] r_xll, r_yll;
    logic [SQ_W-1:0]  r_xsq, r_ysq;
    logic [RAD_W-1:0] r_rad;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // partial products of the split halves
            r_xhh <= PHH_W'(r_mx[MAG_W-1:HALF_LO]) * PHH_W'(r_mx[MAG_W-1:HALF_LO]);
            r_xhl <= PHL_W'(r_mx[MAG_W-1:HALF_LO]) * PHL_W'(r_mx[HALF_LO-1:0]);
            r_xll <= PLL_W'(r_mx[HALF_LO-1:0]) * PLL_W'(r_mx[HALF_LO-1:0]);
            r_yhh <= PHH_W'(r_my[MAG_W-1:HALF_LO]) * PHH_W'(r_my[MAG_W-1:HALF_LO]);
            r_yhl <= PHL_W'(r_my[MAG_W-1:HALF_LO]) * PHL_W'(r_my[HALF_LO-1:0]);
            r_yll <= PLL_W'(r_my[HALF_LO-1:0]) * PLL_W'(r_my[HALF_LO-1:0]);

            // (h*2^L + l)^2 = h^2*2^2L + 2hl*2^L + l^2
            r_xsq <= (SQ_W'(r_xhh) << (2 * HALF_LO)) + (SQ_W'(r_xhl) << (HALF_LO + 1))
                   + SQ_W'(r_xll);
            r_ysq <= (SQ_W'(r_yhh) << (2 * HALF_LO)) + (SQ_W'(r_yhl) << (HALF_LO + 1))
                   + SQ_W'(r_yll);

            // scale by 2^16 so the root carries 8 fraction bits
            r_rad <= {SQ_W'(r_xsq + r_ysq), {(2 * DIST_FRAC){1'b0}}};
        end
    end

    // ------------------------------------------------------------ root and angle
    logic [ROOT_W-1:0]         w_root;
    logic [ROOT_W-1:0]         w_root_d;
    logic signed [ANGLE_W-1:0] w_angle;
    logic signed [ANGLE_W-1:0] w_angle_d;
    t_flags                    w_flags_d;

    c2p_isqrt #(
        .RAD_W (RAD_W)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    c2p_cordic #(
        .MAG_W      (MAG_W),
        .ITERATIONS (ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_ux    (r_mx),
        .i_uy    (r_my),
        .i_ctl   (r_ctl),
        .o_angle (w_angle)
    );

    // Line the two branches and the flags up on the last stage.
    c2p_delay #(
        .WIDTH (ROOT_W),
        .DEPTH (LAST - DIST_STAGE)
    ) u_dist_align (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_data (w_root),
        .o_data (w_root_d)
    );

    c2p_delay #(
        .WIDTH (ANGLE_W),
        .DEPTH (LAST - ANGLE_STAGE)
    ) u_angle_align (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_data (w_angle),
        .o_data (w_angle_d)
    );

    c2p_delay #(
        .WIDTH ($bits(t_flags)),
        .DEPTH (LAST - 2)
    ) u_flag_align (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_data (r_flags),
        .o_data (w_flags_d)
    );

    // ------------------------------------------------------------ output register
    logic [DIST_W-1:0] w_dist_sat;

    if (ROOT_W > DIST_W) begin : g_sat
        // saturate lengths that do not fit the field
        assign w_dist_sat = (w_root_d[ROOT_W-1:DIST_W] != '0) ? '1 : w_root_d[DIST_W-1:0];
    end else begin : g_ext
        assign w_dist_sat = DIST_W'(w_root_d);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_distance  <= w_dist_sat;
            o_at_origin <= w_flags_d.at_origin;
            if (w_flags_d.at_origin) begin
                o_angle <= ANGLE_AT_ORIGIN;
            end else if (w_flags_d.axis) begin
                o_angle <= w_flags_d.axis_angle;
            end else begin
                o_angle <= w_angle_d;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/c2p_checker.sv]
`default_nettype none

`include "cartesian_to_polar_macros.svh"

module c2p_checker
    import c2p_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic [DIST_W-1:0]         i_distance,
    input  logic                      i_at_origin
);

    // a stalled result word stays put
    `C2P_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_angle) && $stable(i_distance) && $stable(i_at_origin))

    // reset empties the pipeline
    `C2P_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

    // a point on the origin has the sentinel angle and zero length
    `C2P_ASSERT_SAME(a_origin_word, i_clk, i_rst_n, i_out_valid && i_at_origin, i_distance == '0 && i_angle == ANGLE_AT_ORIGIN)

    // every other angle lies within +/- pi
    `C2P_ASSERT_SAME(a_angle_range, i_clk, i_rst_n, i_out_valid && !i_at_origin, i_angle >= ANGLE_NEG_PI && i_angle <= ANGLE_PI)

endmodule

bind cartesian_to_polar c2p_checker u_c2p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_angle     (o_angle),
    .i_distance  (o_distance),
    .i_at_origin (o_at_origin)
);

`default_nettype wire
